// ===== rtl/core/edit_distance_engine_core_assert.svh =====
// Assertion macros shared by the edit distance engine checkers.
// Users provide i_clk and i_rst_n in the scope where a macro is expanded.
`ifndef EDIT_DISTANCE_ENGINE_CORE_ASSERT_SVH
`define EDIT_DISTANCE_ENGINE_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define EDE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define EDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ede_pkg.sv =====
// Package of the edit distance engine: field widths, action codes and word types.
// No dependencies; ede_cell, the engine core and the checker refer to it by scoped names.
package ede_pkg;

    localparam int SYM_W  = 8;
    localparam int ACT_W  = 2;
    localparam int DIST_W = 6;

    localparam logic [ACT_W-1:0] ACT_APPEND_FIRST  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND_SECOND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE       = 2'd2;

    // Largest distance the result field can carry; larger values saturate.
    localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [SYM_W-1:0] symbol;
    } t_cmd_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_res_word;

endpackage

// ===== rtl/core/ede_stream_if.sv =====
// Valid/ready stream interface carrying one word of a type chosen per instance.
// Depends on nothing; the word types used with it live in ede_pkg.
interface ede_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ede_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port with registered data.
// No package dependencies; used for both strings and the cost row.
module ede_ram #(
    parameter int  DEPTH = 32,
    parameter int  W     = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/ede_cell.sv =====
// One cell of the edit distance recurrence: minimum of insert, delete and substitute.
// Uses ede_pkg for the symbol width.
module ede_cell #(
    parameter int W = 6
) (
    input  logic [W-1:0]              i_up,
    input  logic [W-1:0]              i_left,
    input  logic [W-1:0]              i_diag,
    input  logic [ede_pkg::SYM_W-1:0] i_sym_a,
    input  logic [ede_pkg::SYM_W-1:0] i_sym_b,
    output logic [W-1:0]              o_cost
);
    // One extra bit so that a cost plus one never wraps.
    logic [W:0] up_c;
    logic [W:0] left_c;
    logic [W:0] sub_c;
    logic [W:0] min_ul;
    logic [W:0] min_all;

    always_comb begin
        up_c    = {1'b0, i_up} + (W+1)'(1);
        left_c  = {1'b0, i_left} + (W+1)'(1);
        sub_c   = {1'b0, i_diag} + (W+1)'(i_sym_a != i_sym_b);
        min_ul  = (up_c < left_c) ? up_c : left_c;
        min_all = (min_ul < sub_c) ? min_ul : sub_c;
    end

    // The minimum never exceeds the longer string length, so it fits in W bits.
    assign o_cost = min_all[W-1:0];
endmodule

// ===== rtl/core/edit_distance_engine_core.sv =====
// Edit distance engine: Levenshtein distance between two byte strings.
// Channels: i_cmd takes command words (action, symbol); o_res gives result
// words (distance, overflow). A word moves when valid and ready are both high.
// Appending a symbol to either string leaves i_cmd ready, so the next word can be
// accepted on the following cycle. A symbol past MAX_LEN is dropped and marks
// the pair as overflowed. An unused action code is accepted and ignored.
// A compute word walks the rows of the first string and then loads the result;
// when either string is empty the walk is skipped and the result loads directly.
// The cost row sits in one RAM with one read and one write port, so the walk
// runs one cell per cycle, with a row start step before each row of the first string.
// i_cmd.ready is low during the whole walk. The result lands in an output
// register; while the receiver stalls it holds, and appends for the next pair
// are still accepted. A finished walk waits for that register to free up.
// After the result is loaded both lengths and the overflow mark are cleared.
// Synchronous active-low reset empties both strings, clears the overflow mark
// and drops any pending result; the RAM contents are not cleared.
// Depends on ede_pkg, ede_stream_if, ede_ram and ede_cell.
module edit_distance_engine_core #(
    parameter int MAX_LEN = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ede_stream_if.sink   i_cmd,
    ede_stream_if.source o_res
);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CMP_W = (LEN_W > ede_pkg::DIST_W) ? LEN_W : ede_pkg::DIST_W;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROW  = 2'd1;
    localparam logic [1:0] S_CELL = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    ede_pkg::t_cmd_word cmd;
    logic               cmd_fire;

    // Control registers.
    logic [1:0]       r_state, n_state;
    logic [LEN_W-1:0] r_len1, n_len1;
    logic [LEN_W-1:0] r_len2, n_len2;
    logic             r_drop, n_drop;
    logic             r_out_valid, n_out_valid;

    // Walk and payload registers.
    logic [LEN_W-1:0]   r_a, n_a;
    logic [LEN_W-1:0]   r_b, n_b;
    logic [LEN_W-1:0]   r_diag, n_diag;
    logic [LEN_W-1:0]   r_left, n_left;
    logic [LEN_W-1:0]   r_res, n_res;
    ede_pkg::t_res_word r_out, n_out;

    // Memory ports.
    logic                      s1_we, s1_re;
    logic                      s2_we, s2_re;
    logic                      row_we, row_re;
    logic [IDX_W-1:0]          s1_raddr, s2_raddr, row_raddr, row_waddr;
    logic [ede_pkg::SYM_W-1:0] s1_rdata, s2_rdata;
    logic [LEN_W-1:0]          row_rdata;

    logic [LEN_W-1:0] a_m1;
    logic [LEN_W-1:0] b_m1;
    logic [LEN_W-1:0] up;
    logic [LEN_W-1:0] cell_cost;
    logic [CMP_W-1:0] res_wide;
    logic             res_sat;

    assign cmd           = i_cmd.data;
    assign i_cmd.ready   = (r_state == S_IDLE);
    assign cmd_fire      = i_cmd.valid && i_cmd.ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.data    = r_out;

    assign a_m1      = r_a - LEN_ONE;
    assign b_m1      = r_b - LEN_ONE;
    assign row_waddr = b_m1[IDX_W-1:0];

    // Column zero of the row is never stored: its old value is a-1 and its new
    // value is a. On the first row the value from above is simply b.
    assign up = (r_a == LEN_ONE) ? r_b : row_rdata;

    assign res_wide = CMP_W'(r_res);
    assign res_sat  = (res_wide > CMP_W'(ede_pkg::DIST_MAX));

    ede_ram #(
        .DEPTH (MAX_LEN),
        .W     (ede_pkg::SYM_W)
    ) u_first_str (
        .i_clk   (i_clk),
        .i_we    (s1_we),
        .i_waddr (r_len1[IDX_W-1:0]),
        .i_wdata (cmd.symbol),
        .i_re    (s1_re),
        .i_raddr (s1_raddr),
        .o_rdata (s1_rdata)
    );

    ede_ram #(
        .DEPTH (MAX_LEN),
        .W     (ede_pkg::SYM_W)
    ) u_second_str (
        .i_clk   (i_clk),
        .i_we    (s2_we),
        .i_waddr (r_len2[IDX_W-1:0]),
        .i_wdata (cmd.symbol),
        .i_re    (s2_re),
        .i_raddr (s2_raddr),
        .o_rdata (s2_rdata)
    );

    // Cost row, entry b-1 holds column b. Within a row the cell writes column b
    // while reading column b+1, so the two never collide. The first read of a row
    // is issued in the row start state, after the last write of the row before.
    ede_ram #(
        .DEPTH (MAX_LEN),
        .W     (LEN_W)
    ) u_cost_row (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (cell_cost),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    ede_cell #(
        .W (LEN_W)
    ) u_cell (
        .i_up    (up),
        .i_left  (r_left),
        .i_diag  (r_diag),
        .i_sym_a (s1_rdata),
        .i_sym_b (s2_rdata),
        .o_cost  (cell_cost)
    );

    always_comb begin
        n_state     = r_state;
        n_len1      = r_len1;
        n_len2      = r_len2;
        n_drop      = r_drop;
        n_out_valid = r_out_valid;
        n_a         = r_a;
        n_b         = r_b;
        n_diag      = r_diag;
        n_left      = r_left;
        n_res       = r_res;
        n_out       = r_out;
        s1_we       = 1'b0;
        s2_we       = 1'b0;
        s1_re       = 1'b0;
        s2_re       = 1'b0;
        row_we      = 1'b0;
        row_re      = 1'b0;
        s1_raddr    = a_m1[IDX_W-1:0];
        s2_raddr    = '0;
        row_raddr   = '0;

        if (o_res.valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    case (cmd.action)
                        ede_pkg::ACT_APPEND_FIRST: begin
                            if (r_len1 < LEN_MAX) begin
                                s1_we  = 1'b1;
                                n_len1 = r_len1 + LEN_ONE;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        ede_pkg::ACT_APPEND_SECOND: begin
                            if (r_len2 < LEN_MAX) begin
                                s2_we  = 1'b1;
                                n_len2 = r_len2 + LEN_ONE;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        ede_pkg::ACT_COMPUTE: begin
                            if ((r_len1 == '0) || (r_len2 == '0)) begin
                                // With one string empty the distance is the other length.
                                n_res   = r_len1 | r_len2;
                                n_state = S_FIN;
                            end else begin
                                n_a     = LEN_ONE;
                                n_state = S_ROW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ROW: begin
                // Fetch this row's symbol of the first string and column one.
                s1_re   = 1'b1;
                s2_re   = 1'b1;
                row_re  = 1'b1;
                n_diag  = a_m1;
                n_left  = r_a;
                n_b     = LEN_ONE;
                n_state = S_CELL;
            end
            S_CELL: begin
                row_we = 1'b1;
                n_diag = up;
                n_left = cell_cost;
                if (r_b == r_len2) begin
                    if (r_a == r_len1) begin
                        n_res   = cell_cost;
                        n_state = S_FIN;
                    end else begin
                        n_a     = r_a + LEN_ONE;
                        n_state = S_ROW;
                    end
                end else begin
                    s2_re     = 1'b1;
                    row_re    = 1'b1;
                    s2_raddr  = r_b[IDX_W-1:0];
                    row_raddr = r_b[IDX_W-1:0];
                    n_b       = r_b + LEN_ONE;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid    = 1'b1;
                    n_out.distance = res_sat ? ede_pkg::DIST_MAX
                                             : res_wide[ede_pkg::DIST_W-1:0];
                    n_out.overflow = r_drop || res_sat;
                    n_len1         = '0;
                    n_len2         = '0;
                    n_drop         = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len1      <= '0;
            r_len2      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len1      <= n_len1;
            r_len2      <= n_len2;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_diag <= n_diag;
        r_left <= n_left;
        r_res  <= n_res;
        r_out  <= n_out;
    end
endmodule

// ===== rtl/core/ede_checker.sv =====
// Port-level checker for the edit distance engine, bound to its top level.
// Depends on ede_pkg and the assertion macros in edit_distance_engine_core_assert.svh.
`include "edit_distance_engine_core_assert.svh"

module ede_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cmd_valid,
    input logic                        i_cmd_ready,
    input logic [ede_pkg::ACT_W-1:0]   i_cmd_action,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input ede_pkg::t_res_word          i_res_data
);
    logic cmd_fire;
    logic is_compute;

    assign cmd_fire   = i_cmd_valid && i_cmd_ready;
    assign is_compute = (i_cmd_action == ede_pkg::ACT_COMPUTE);

    `EDE_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid, "result word dropped while stalled")
    `EDE_ASSERT_NEXT(a_res_stable, i_res_valid && !i_res_ready, $stable(i_res_data), "result word changed while stalled")
    `EDE_ASSERT_NEXT(a_compute_busy, cmd_fire && is_compute, !i_cmd_ready, "command taken right after a compute")
    `EDE_ASSERT_NEXT(a_append_quick, cmd_fire && !is_compute, i_cmd_ready, "append did not finish in one cycle")
    `EDE_ASSERT_SAME(a_res_from_walk, $rose(i_res_valid), !$past(i_cmd_ready), "result appeared without a compute")
endmodule

bind edit_distance_engine_core ede_checker u_ede_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_cmd_action (i_cmd.data.action),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_data   (o_res.data)
);
